// ===== hw/rtl/qfts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_pkg
// word types and status codes shared by the two-stack queue
// ----------------------------------------------------------------------------
package qfts_pkg;

  localparam int WORD_W = 32;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic signed [WORD_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    status_t                  status;
    logic                     queue_empty;
  } rsp_word_t;

endpackage

// ===== hw/rtl/qfts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module qfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/qfts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfts_ctrl
// sequencer, stack pointers and response register of the two-stack queue
// ----------------------------------------------------------------------------
module qfts_ctrl #(
  parameter int STACK_DEPTH = 128,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  qfts_pkg::cmd_word_t               cmd,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output qfts_pkg::rsp_word_t               rsp,
  // inbound stack ram
  output logic                              in_we,
  output logic [AW-1:0]                     in_waddr,
  output logic [qfts_pkg::WORD_W-1:0]       in_wdata,
  output logic [AW-1:0]                     in_raddr,
  input  logic [qfts_pkg::WORD_W-1:0]       in_rdata,
  // outbound stack ram
  output logic                              out_we,
  output logic [AW-1:0]                     out_waddr,
  output logic [qfts_pkg::WORD_W-1:0]       out_wdata,
  output logic [AW-1:0]                     out_raddr,
  input  logic [qfts_pkg::WORD_W-1:0]       out_rdata
);

  import qfts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_XFER = 5'b00010,
    S_POP  = 5'b00100,
    S_WAIT = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t              state;
  logic [CW-1:0]       in_count;
  logic [CW-1:0]       out_count;
  logic [CW-1:0]       in_count_m1;
  logic [CW-1:0]       out_count_m1;
  logic                rd_valid;
  logic [WORD_W-1:0]   res_data;
  status_t             res_status;
  logic                accept;
  logic                in_full;
  logic                rsp_load;

  assign cmd_ready    = (state == S_IDLE);
  assign accept       = cmd_valid && cmd_ready;
  assign in_full      = (in_count == CW'(STACK_DEPTH));
  assign in_count_m1  = in_count - 1'b1;
  assign out_count_m1 = out_count - 1'b1;
  assign rsp_load     = (state == S_RESP) && (!rsp_valid || rsp_ready);

  // push on enqueue, read the inbound top while moving entries across
  assign in_we    = accept && (cmd.operation == OP_ENQ) && !in_full;
  assign in_waddr = in_count[AW-1:0];
  assign in_wdata = cmd.value;
  assign in_raddr = in_count_m1[AW-1:0];

  // write side of the transfer follows the registered inbound read in the next cycle
  assign out_we    = (state == S_XFER) && rd_valid;
  assign out_waddr = out_count[AW-1:0];
  assign out_wdata = in_rdata;
  assign out_raddr = out_count_m1[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.operation == OP_ENQ) begin
              if (!in_full) begin
                in_count <= in_count + 1'b1;
              end
              state <= S_RESP;
            end else if (out_count != '0) begin
              state <= S_POP;
            end else if (in_count != '0) begin
              rd_valid <= 1'b0;
              state    <= S_XFER;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_XFER: begin
          if (in_count != '0) begin
            in_count <= in_count_m1;
          end
          rd_valid <= (in_count != '0);
          if (rd_valid) begin
            out_count <= out_count + 1'b1;
          end
          if (in_count == '0) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          out_count <= out_count_m1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= '0;
      if (cmd.operation == OP_ENQ) begin
        res_status <= in_full ? ST_OVERFLOW : ST_OK;
      end else begin
        res_status <= (out_count == '0 && in_count == '0) ? ST_EMPTY : ST_OK;
      end
    end else if (state == S_WAIT) begin
      res_data <= out_rdata;
    end
    if (rsp_load) begin
      rsp.data_out    <= res_data;
      rsp.status      <= res_status;
      rsp.queue_empty <= (in_count == '0) && (out_count == '0);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (in_count <= CW'(STACK_DEPTH)) && (out_count <= CW'(STACK_DEPTH)))
    else $error("stack count beyond depth");

  a_xfer_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_XFER) |-> (out_count == '0) && (in_count != '0))
    else $error("transfer started with entries in outbound stack");

  a_xfer_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_XFER) && $past(state == S_XFER) |->
      ({1'b0, in_count} + {1'b0, out_count} + (CW+1)'(rd_valid)) ==
      $past({1'b0, in_count} + {1'b0, out_count} + (CW+1)'(rd_valid)))
    else $error("entry lost or duplicated during transfer");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.queue_empty)
    else $error("empty status without empty flag");

endmodule

// ===== hw/rtl/queue_from_two_stacks.sv =====
`timescale 1ns / 1ps
// sequence: an enqueue goes from idle straight to the response state; a dequeue
// from a filled outbound stack passes the pop and wait states first, and one from
// an empty one first moves every inbound entry across in the transfer state
// handshake: one word at a time; cmd_ready is high only while the sequencer idles;
// each entry crosses from the inbound to the outbound stack once
// reset: rst synchronous, active high; both stacks empty, no response pending
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// first-in first-out queue made of two ram-backed stacks with one sequencer
// ----------------------------------------------------------------------------
module queue_from_two_stacks #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  qfts_pkg::cmd_word_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output qfts_pkg::rsp_word_t rsp
);

  import qfts_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  // inbound stack port
  logic              in_we;
  logic [AW-1:0]     in_waddr;
  logic [WORD_W-1:0] in_wdata;
  logic [AW-1:0]     in_raddr;
  logic [WORD_W-1:0] in_rdata;

  // outbound stack port
  logic              out_we;
  logic [AW-1:0]     out_waddr;
  logic [WORD_W-1:0] out_wdata;
  logic [AW-1:0]     out_raddr;
  logic [WORD_W-1:0] out_rdata;

  // sequencer: pointers, transfer loop and the response register, so a new
  // word may be taken while the previous response still waits on rsp_ready
  qfts_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .in_we     (in_we),
    .in_waddr  (in_waddr),
    .in_wdata  (in_wdata),
    .in_raddr  (in_raddr),
    .in_rdata  (in_rdata),
    .out_we    (out_we),
    .out_waddr (out_waddr),
    .out_wdata (out_wdata),
    .out_raddr (out_raddr),
    .out_rdata (out_rdata)
  );

  // inbound stack: written on enqueue, read top first during a transfer
  qfts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  // outbound stack: filled in reversed order, popped on dequeue
  qfts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

endmodule
